// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL; the segment parser top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on clk_i, muted while rst_ni is low.
`define TLMSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never hold.
`define TLMSP_ASSERT_NEVER(lbl, cond, msg) \
  `TLMSP_ASSERT(lbl, !(cond), msg)

`endif

// File: hw/rtl/tlmsp_pkg.sv
// Types, constants and helpers for the TLM segment parser.
package tlmsp_pkg;

  localparam int unsigned LenW    = 16;
  localparam int unsigned CountW  = 15;
  localparam int unsigned SizeW   = 3;
  localparam int unsigned PartW   = 32;

  localparam logic [LenW-1:0] HdrBytes = 16'd4;
  localparam logic [7:0]      StMask   = 8'h30;

  // SP codes
  localparam logic [1:0] SpShort = 2'd0;
  localparam logic [1:0] SpLong  = 2'd1;
  // ST code that has no meaning
  localparam logic [1:0] StBad   = 2'd3;

  // result kinds
  localparam logic KindHeader = 1'b0;
  localparam logic KindEntry  = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       segment_start;
  } in_t;

  typedef struct packed {
    logic              result_kind;
    logic [LenW-1:0]   segment_length;
    logic [7:0]        segment_index;
    logic [1:0]        index_size;
    logic [1:0]        length_size;
    logic [CountW-1:0] entry_count;
    logic              bad_format;
    logic [15:0]       tile_index;
    logic [PartW-1:0]  part_length;
    logic [CountW-1:0] entry_number;
    logic              last_entry;
  } out_t;

  typedef struct packed {
    logic             start;
    logic [LenW-1:0]  dividend;
    logic [SizeW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            valid;
    logic [LenW-1:0] quot;
  } div_rsp_t;

  // bytes in one entry: ST index bytes plus 2 or 4 length bytes
  function automatic logic [SizeW-1:0] entry_size(input logic [1:0] st, input logic [1:0] sp);
    logic [SizeW-1:0] plen;
    plen = (sp == SpShort) ? 3'd2 : 3'd4;
    return {1'b0, st} + plen;
  endfunction

  function automatic logic fmt_bad(input logic [1:0] st, input logic [1:0] sp);
    return (st == StBad) || (sp != SpShort && sp != SpLong);
  endfunction

endpackage

// File: hw/rtl/tlmsp_div.sv
// Bit-serial restoring divider: 16-bit dividend by a small entry size.
module tlmsp_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tlmsp_pkg::div_req_t req_i,
  output tlmsp_pkg::div_rsp_t rsp_o
);
  import tlmsp_pkg::*;

  localparam int unsigned CntW = $clog2(LenW);
  localparam logic [CntW-1:0] LastStep = CntW'(LenW - 1);

  logic            busy_q, busy_d;
  logic            valid_q, valid_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [LenW-1:0] num_q, num_d;
  logic [SizeW-1:0] rem_q, rem_d;
  logic [SizeW-1:0] den_q, den_d;

  logic [SizeW:0] partial;
  logic [SizeW:0] diff;
  logic           ge;

  always_comb begin
    partial = {rem_q, num_q[LenW-1]};
    diff    = partial - {1'b0, den_q};
    ge      = partial >= {1'b0, den_q};

    busy_d  = busy_q;
    valid_d = valid_q;
    cnt_d   = cnt_q;
    num_d   = num_q;
    rem_d   = rem_q;
    den_d   = den_q;

    if (req_i.start) begin
      busy_d  = 1'b1;
      valid_d = 1'b0;
      cnt_d   = '0;
      num_d   = req_i.dividend;
      rem_d   = '0;
      den_d   = req_i.divisor;
    end else if (busy_q) begin
      // quotient bits shift in behind the dividend
      num_d = {num_q[LenW-2:0], ge};
      rem_d = ge ? diff[SizeW-1:0] : partial[SizeW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d  = 1'b0;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.busy  = busy_q;
  assign rsp_o.valid = valid_q;
  assign rsp_o.quot  = num_q;

endmodule

// File: hw/rtl/tlm_segment_parser.sv
// TLM marker segment parser top level: byte sequencer, divider, output register.
//
//  channel | signals                               | word
//  --------+---------------------------------------+------------------------------
//  in      | in_valid_i / in_ready_o / in_data_i   | one segment byte + start flag
//  out     | out_valid_o / out_ready_i / out_data_o| header or tile-part entry
//
// Bytes are taken while the output register is free, except the size byte: it
// starts the 16-step serial divider for the entry count, and input stays stalled
// through the division and, while the output register is still full, beyond it,
// until the header word is loaded into the output register.
// A byte is taken while an earlier word waits only if the output register
// is taken in the same cycle, whether or not the byte makes a word.
// Reset returns the sequencer to idle and empties the output register.
module tlm_segment_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tlmsp_pkg::in_t    in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tlmsp_pkg::out_t   out_data_o
);
  import tlmsp_pkg::*;

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StLenLo  = 7'b0000010,
    StIndex  = 7'b0000100,
    StSizes  = 7'b0001000,
    StDivide = 7'b0010000,
    StEntry  = 7'b0100000,
    StSkip   = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic [LenW-1:0]   seg_len_q, seg_len_d;
  logic [7:0]        seg_idx_q, seg_idx_d;
  logic [1:0]        st_q, st_d;
  logic [1:0]        sp_q, sp_d;
  logic [CountW-1:0] count_q, count_d;
  logic [LenW-1:0]   left_q, left_d;
  logic [CountW-1:0] ent_q, ent_d;
  logic [SizeW-1:0]  bie_q, bie_d;
  logic [15:0]       idx_acc_q, idx_acc_d;
  logic [PartW-1:0]  len_acc_q, len_acc_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              out_free;
  logic              in_fire;
  logic              emit;
  logic [7:0]        byte_in;
  logic [1:0]        st_in, sp_in;
  logic [SizeW-1:0]  esize;
  logic [SizeW-1:0]  bie_nx;
  logic [15:0]       idx_nx;
  logic [PartW-1:0]  len_nx;
  logic [LenW-1:0]   left_nx;
  logic              last;
  logic              bad;
  logic [CountW-1:0] hdr_count;

  tlmsp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q != StDivide) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign byte_in = in_data_i.data_byte;
  assign st_in   = 2'((byte_in & StMask) >> 4);
  assign sp_in   = byte_in[7:6];
  assign esize   = entry_size(st_q, sp_q);

  always_comb begin
    state_d     = state_q;
    seg_len_d   = seg_len_q;
    seg_idx_d   = seg_idx_q;
    st_d        = st_q;
    sp_d        = sp_q;
    count_d     = count_q;
    left_d      = left_q;
    ent_d       = ent_q;
    bie_d       = bie_q;
    idx_acc_d   = idx_acc_q;
    len_acc_d   = len_acc_q;
    out_d       = out_q;
    emit        = 1'b0;
    div_req     = '0;

    bie_nx    = bie_q + 1'b1;
    idx_nx    = {idx_acc_q[7:0], byte_in};
    len_nx    = {len_acc_q[PartW-9:0], byte_in};
    left_nx   = left_q - 1'b1;
    bad       = fmt_bad(st_q, sp_q);
    hdr_count = div_rsp.quot[CountW-1:0];
    last      = 1'b0;

    // common header fields of every word
    out_d.segment_length = seg_len_q;
    out_d.segment_index  = seg_idx_q;
    out_d.index_size     = st_q;
    out_d.length_size    = sp_q;
    out_d.entry_count    = count_q;
    out_d.bad_format     = bad;

    if (state_q == StDivide) begin
      if (div_rsp.valid && out_free) begin
        last                = bad || (hdr_count == '0);
        emit                = 1'b1;
        count_d             = hdr_count;
        out_d.result_kind   = KindHeader;
        out_d.entry_count   = hdr_count;
        out_d.tile_index    = '0;
        out_d.part_length   = '0;
        out_d.entry_number  = '0;
        out_d.last_entry    = last;
        if (last) begin
          state_d = (left_q != '0) ? StSkip : StIdle;
        end else begin
          state_d = StEntry;
        end
      end
    end else if (in_fire) begin
      if (in_data_i.segment_start) begin
        seg_len_d = {byte_in, 8'h00};
        state_d   = StLenLo;
      end else begin
        case (state_q)
          StLenLo: begin
            seg_len_d = {seg_len_q[LenW-1:8], byte_in};
            state_d   = StIndex;
          end
          StIndex: begin
            seg_idx_d = byte_in;
            state_d   = StSizes;
          end
          StSizes: begin
            st_d      = st_in;
            sp_d      = sp_in;
            left_d    = (seg_len_q >= HdrBytes) ? seg_len_q - HdrBytes : '0;
            ent_d     = '0;
            bie_d     = '0;
            idx_acc_d = '0;
            len_acc_d = '0;
            div_req.start    = 1'b1;
            div_req.dividend = left_d;
            div_req.divisor  = entry_size(st_in, sp_in);
            state_d   = StDivide;
          end
          StEntry: begin
            left_d = left_nx;
            if ({1'b0, bie_q} < {1'b0, st_q}) begin
              idx_acc_d = idx_nx;
            end else begin
              len_acc_d = len_nx;
            end
            if (bie_nx >= esize) begin
              last               = ({1'b0, ent_q} + 16'd1) >= {1'b0, count_q};
              emit               = 1'b1;
              out_d.result_kind  = KindEntry;
              out_d.tile_index   = (st_q == 2'd0) ? {1'b0, ent_q} : idx_acc_d;
              out_d.part_length  = len_acc_d;
              out_d.entry_number = ent_q;
              out_d.last_entry   = last;
              ent_d              = ent_q + 1'b1;
              bie_d              = '0;
              idx_acc_d          = '0;
              len_acc_d          = '0;
              if (last) begin
                state_d = (left_nx != '0) ? StSkip : StIdle;
              end
            end else begin
              bie_d = bie_nx;
            end
          end
          StSkip: begin
            if (left_q != '0) begin
              left_d = left_nx;
            end
            if (left_d == '0) begin
              state_d = StIdle;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      seg_len_q   <= '0;
      seg_idx_q   <= '0;
      st_q        <= '0;
      sp_q        <= SpLong;
      count_q     <= '0;
      left_q      <= '0;
      ent_q       <= '0;
      bie_q       <= '0;
      idx_acc_q   <= '0;
      len_acc_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seg_len_q   <= seg_len_d;
      seg_idx_q   <= seg_idx_d;
      st_q        <= st_d;
      sp_q        <= sp_d;
      count_q     <= count_d;
      left_q      <= left_d;
      ent_q       <= ent_d;
      bie_q       <= bie_d;
      idx_acc_q   <= idx_acc_d;
      len_acc_q   <= len_acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `include "assert_macros.svh"

  // entries never run past the count taken from the header
  `TLMSP_ASSERT(a_entry_in_range,
    (out_valid_o && out_data_o.result_kind == KindEntry) |->
      (out_data_o.entry_number < out_data_o.entry_count),
    "entry number beyond entry count")
  // a bad format header closes the run
  `TLMSP_ASSERT(a_bad_is_last,
    (out_valid_o && out_data_o.bad_format) |-> out_data_o.last_entry,
    "bad format word not marked last")
  // byte position stays inside one entry
  `TLMSP_ASSERT(a_bie_in_entry,
    (state_q == StEntry) |-> (bie_q < esize),
    "byte position past entry size")
  // header only leaves the divide state, once the divider is done
  `TLMSP_ASSERT(a_hdr_after_div,
    (emit && out_d.result_kind == KindHeader) |-> (state_q == StDivide && div_rsp.valid),
    "header word without a finished division")
  // the divider is never restarted while it runs
  `TLMSP_ASSERT_NEVER(a_div_overlap, div_req.start && div_rsp.busy,
    "divider started while busy")

endmodule

// File: tb/tlm_segment_parser_tb.sv
// Self-checking testbench for the TLM marker segment parser, with its own parse model.
module tlm_segment_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tlmsp_pkg::*;

  localparam int unsigned ByteTarget  = 1200;
  localparam int unsigned IdlePct     = 16;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned DrainCycles = 40;

  typedef enum logic [2:0] {
    PhIdle, PhLenLo, PhIndex, PhSizes, PhEntry, PhSkip
  } phase_e;

  typedef struct {
    in_t  din;
    bit   typed;
    out_t want;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  tlm_segment_parser uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // parse model state
  phase_e      ph;
  logic [15:0] left_cnt;
  logic [15:0] seg_len;
  logic [7:0]  seg_idx;
  logic [1:0]  st_q;
  logic [1:0]  sp_q;
  logic [14:0] cnt_q;
  logic [14:0] ent_num;
  logic [2:0]  pos_q;
  logic [15:0] idx_acc;
  logic [31:0] len_acc;

  out_t  pending_words[$];
  row_t  dir_rows[$];
  int    fed_cnt;
  int    fail_cnt;
  int    quiet_cycles;
  logic  idling_on;

  function automatic out_t mk_word(logic kind, logic [15:0] len, logic [7:0] idx,
                                   logic [1:0] st, logic [1:0] sp, logic [14:0] cnt,
                                   logic bad, logic [15:0] tile, logic [31:0] plen,
                                   logic [14:0] num, logic last);
    return '{kind, len, idx, st, sp, cnt, bad, tile, plen, num, last};
  endfunction

  function automatic logic fmt_is_bad();
    return (st_q == StBad) || (sp_q > SpLong);
  endfunction

  function automatic logic [2:0] ent_bytes();
    return {1'b0, st_q} + ((sp_q == SpShort) ? 3'd2 : 3'd4);
  endfunction

  function automatic out_t seg_word(logic kind, logic [15:0] tile, logic [31:0] plen,
                                    logic [14:0] num, logic last);
    return mk_word(kind, seg_len, seg_idx, st_q, sp_q, cnt_q, fmt_is_bad(),
                   tile, plen, num, last);
  endfunction

  function automatic void reset_parse_model();
    ph       = PhIdle;
    left_cnt = '0;
    seg_len  = '0;
    seg_idx  = '0;
    st_q     = '0;
    sp_q     = SpLong;
    cnt_q    = '0;
    ent_num  = '0;
    pos_q    = '0;
    idx_acc  = '0;
    len_acc  = '0;
  endfunction

  // advance the model by one byte; returns 1 when the byte produces a word
  function automatic bit parse_byte(input in_t d, output out_t res);
    logic [7:0] b;
    logic       fin;
    res = '0;
    b = d.data_byte;
    if (d.segment_start) begin
      seg_len = {b, 8'h00};
      ph = PhLenLo;
      return 1'b0;
    end
    case (ph)
      PhLenLo: begin
        seg_len[7:0] = b;
        ph = PhIndex;
        return 1'b0;
      end
      PhIndex: begin
        seg_idx = b;
        ph = PhSizes;
        return 1'b0;
      end
      PhSizes: begin
        st_q = 2'((b & StMask) >> 4);
        sp_q = b[7:6];
        if (seg_len >= HdrBytes) begin
          left_cnt = seg_len - HdrBytes;
          cnt_q = 15'(left_cnt / ent_bytes());
        end else begin
          left_cnt = '0;
          cnt_q = '0;
        end
        ent_num = '0;
        pos_q   = '0;
        idx_acc = '0;
        len_acc = '0;
        fin = fmt_is_bad() || (cnt_q == '0);
        res = seg_word(KindHeader, 16'd0, 32'd0, 15'd0, fin);
        if (fin) ph = (left_cnt != '0) ? PhSkip : PhIdle;
        else ph = PhEntry;
        return 1'b1;
      end
      PhEntry: begin
        left_cnt = left_cnt - 16'd1;
        if (pos_q < {1'b0, st_q}) idx_acc = {idx_acc[7:0], b};
        else len_acc = {len_acc[23:0], b};
        pos_q = pos_q + 3'd1;
        if (pos_q >= ent_bytes()) begin
          fin = (32'(ent_num) + 32'd1 >= 32'(cnt_q));
          res = seg_word(KindEntry, (st_q == 2'd0) ? {1'b0, ent_num} : idx_acc,
                         len_acc, ent_num, fin);
          ent_num = ent_num + 15'd1;
          pos_q   = '0;
          idx_acc = '0;
          len_acc = '0;
          if (fin) ph = (left_cnt != '0) ? PhSkip : PhIdle;
          return 1'b1;
        end
        return 1'b0;
      end
      PhSkip: begin
        if (left_cnt != '0) left_cnt = left_cnt - 16'd1;
        if (left_cnt == '0) ph = PhIdle;
        return 1'b0;
      end
      PhIdle: return 1'b0;
      default: begin
        ph = PhIdle;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void add_row(logic [7:0] b, logic s, bit typed = 1'b0,
                                  out_t want = '0);
    row_t r;
    r.din   = '{b, s};
    r.typed = typed;
    r.want  = want;
    dir_rows.push_back(r);
  endfunction

  // offer one word, wait for it to be taken, then queue what it should produce
  task automatic send_word(in_t d, bit typed, out_t want);
    out_t res;
    bit   has;
    bit   ignored;
    while (idling_on && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (!in_ready_o);
    ignored = (ph == PhIdle) && !d.segment_start;
    has = parse_byte(d, res);
    if (typed) pending_words.push_back(want);
    else if (has) pending_words.push_back(res);
    if (!ignored) fed_cnt++;
  endtask

  task automatic send_rand_segment();
    in_t        seg[$];
    logic [1:0] st;
    logic [1:0] sp;
    int         es;
    int         n;
    int         extra;
    int         len;
    int         payload;
    int         keep;
    int         mode;
    // stray bytes between segments
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(3, 1)) seg.push_back(in_t'{8'($urandom), 1'b0});
    end
    st = ($urandom_range(9) == 0) ? StBad : 2'($urandom_range(2));
    sp = ($urandom_range(9) == 0) ? 2'($urandom_range(3, 2)) : 2'($urandom_range(1));
    es = int'(st) + ((sp == SpShort) ? 2 : 4);
    n = $urandom_range(6);
    extra = ($urandom_range(3) == 0) ? $urandom_range(es - 1) : 0;
    len = 4 + n * es + extra;
    mode = $urandom_range(99);
    if (mode < 6) len = $urandom_range(3);
    else if (mode < 10) len = $urandom_range(65535);
    seg.push_back(in_t'{8'(len >> 8), 1'b1});
    seg.push_back(in_t'{8'(len), 1'b0});
    seg.push_back(in_t'{8'($urandom), 1'b0});
    seg.push_back(in_t'{{sp, st, 4'($urandom)}, 1'b0});
    payload = (len > 4) ? len - 4 : 0;
    if (payload > 48) payload = $urandom_range(48);
    repeat (payload) seg.push_back(in_t'{8'($urandom), 1'b0});
    // cut short so the next start drops it
    if ($urandom_range(99) < 8) begin
      keep = $urandom_range(seg.size() - 1, 1);
      while (seg.size() > keep) void'(seg.pop_back());
    end
    foreach (seg[i]) send_word(seg[i], 1'b0, '0);
  endtask

  // output side: random stalls and word check
  always @(posedge clk_i) begin
    out_t want;
    bit   bad;
    if (rst_ni && out_valid_o && out_ready_i) begin
      bad = 1'b0;
      if (pending_words.size() == 0) begin
        bad = 1'b1;
        if (fail_cnt < 10) $display("unexpected word: %p", out_data_o);
      end else begin
        want = pending_words.pop_front();
        if (out_data_o !== want) begin
          bad = 1'b1;
          if (fail_cnt < 10) $display("mismatch: expected %p, got %p", want, out_data_o);
        end
      end
      if (bad) fail_cnt++;
    end
    out_ready_i <= (idling_on && $urandom_range(99) < IdlePct) ? 1'b0 : 1'b1;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_ready_i  = 1'b0;
    idling_on    = 1'b1;
    fed_cnt      = 0;
    fail_cnt     = 0;
    quiet_cycles = 0;
    reset_parse_model();

    // ignored while idle, then an extreme length dropped by a restart
    add_row(8'hA5, 1'b0);
    add_row(8'hFF, 1'b1);
    add_row(8'hFF, 1'b0);
    // length 4: header only
    add_row(8'h00, 1'b1);
    add_row(8'h04, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'h40, 1'b0, 1'b1, mk_word(KindHeader, 16'd4, 8'hFF, 2'd0, SpLong,
                                       15'd0, 1'b0, 16'd0, 32'd0, 15'd0, 1'b1));
    // length below 4, invalid ST and SP
    add_row(8'h00, 1'b1);
    add_row(8'h02, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'hFF, 1'b0, 1'b1, mk_word(KindHeader, 16'd2, 8'h00, StBad, 2'd3,
                                       15'd0, 1'b1, 16'd0, 32'd0, 15'd0, 1'b1));
    // invalid SP, one byte skipped
    add_row(8'h00, 1'b1);
    add_row(8'h05, 1'b0);
    add_row(8'h01, 1'b0);
    add_row(8'h80, 1'b0, 1'b1, mk_word(KindHeader, 16'd5, 8'h01, 2'd0, 2'd2,
                                       15'd0, 1'b1, 16'd0, 32'd0, 15'd0, 1'b1));
    add_row(8'h33, 1'b0);
    // ST 0, 16-bit lengths, one entry plus a leftover byte
    add_row(8'h00, 1'b1);
    add_row(8'h07, 1'b0);
    add_row(8'h02, 1'b0);
    add_row(8'h0F, 1'b0, 1'b1, mk_word(KindHeader, 16'd7, 8'h02, 2'd0, SpShort,
                                       15'd1, 1'b0, 16'd0, 32'd0, 15'd0, 1'b0));
    add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0, 1'b1, mk_word(KindEntry, 16'd7, 8'h02, 2'd0, SpShort,
                                       15'd1, 1'b0, 16'd0, 32'h0000_FFFF, 15'd0, 1'b1));
    add_row(8'h12, 1'b0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_word(dir_rows[i].din, dir_rows[i].typed, dir_rows[i].want);

    while (fed_cnt < ByteTarget) begin
      idling_on <= !(fed_cnt >= 400 && fed_cnt < 700);
      send_rand_segment();
    end
    in_valid_i <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
